@@ hdl/pdp_pkg.sv @@
// Shared types, constants and fixed-point helpers of the pinhole projection unit.
`timescale 1ns / 1ps
package pdp_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_RADIAL_1  = 3'd4;
   localparam logic [2:0] REG_RADIAL_2  = 3'd5;
   localparam logic [2:0] REG_TANGENT_1 = 3'd6;
   localparam logic [2:0] REG_TANGENT_2 = 3'd7;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DEPTH = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   // Quotient bits of the depth divider: 32-bit magnitude shifted up by 24
   localparam int DIV_STEPS = 56;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [47:0] Q24_ONE = 48'sd16777216;

   typedef struct packed {
      logic              sat;
      logic signed [31:0] val;
   } clip_type;

   // One lane of the restoring divider
   typedef struct packed {
      logic [DIV_STEPS-1:0] num;
      logic [31:0]          rem;
      logic [DIV_STEPS-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic        bad;
      logic        neg_x;
      logic        neg_y;
      logic [30:0] den;
      lane_type    lx;
      lane_type    ly;
   } div_type;

   // Clip a wide signed value to 32 bits and flag it
   function automatic clip_type clip48(input logic signed [47:0] v);
      clip_type r;
      r.sat = 1'b0;
      r.val = v[31:0];
      if (v > 48'sh0000_7FFF_FFFF) begin
         r.sat = 1'b1;
         r.val = S32_MAX;
      end else if (v < -48'sh0000_8000_0000) begin
         r.sat = 1'b1;
         r.val = S32_MIN;
      end
      return r;
   endfunction

   // Q8.24 product: floor shift by 24, then clip
   function automatic clip_type qscale(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 24;
      return clip48(s[47:0]);
   endfunction

   // One restoring division step
   function automatic lane_type div_step(input lane_type l, input logic [30:0] den);
      lane_type    r;
      logic [32:0] trial;
      trial = {l.rem, l.num[DIV_STEPS-1]};
      if (trial >= {2'b00, den}) begin
         r.rem = 32'(trial - {2'b00, den});
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
      end else begin
         r.rem = trial[31:0];
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
      end
      r.num = {l.num[DIV_STEPS-2:0], 1'b0};
      return r;
   endfunction

   // Signed quotient from magnitude and sign, clipped
   function automatic clip_type quo_clip(input logic [DIV_STEPS-1:0] q, input logic neg);
      clip_type r;
      if (!neg) begin
         r.sat = |q[DIV_STEPS-1:31];
         r.val = r.sat ? S32_MAX : $signed(q[31:0]);
      end else begin
         r.sat = (|q[DIV_STEPS-1:32]) | (q[31] & (|q[30:0]));
         r.val = r.sat ? S32_MIN : $signed(32'(32'd0 - q[31:0]));
      end
      return r;
   endfunction

endpackage

@@ hdl/pdp_if.sv @@
// Point and pixel stream interfaces of the pinhole projection unit.
`timescale 1ns / 1ps
interface pdp_point_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pdp_pixel_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] pixel_u;
   logic signed [31:0] pixel_v;
   logic [1:0]         status;
   modport source (output valid, pixel_u, pixel_v, status, input ready);
   modport sink   (input valid, pixel_u, pixel_v, status, output ready);
endinterface

@@ hdl/pinhole_distortion_projection_unit.sv @@
// Pinhole projection with Brown-Conrady distortion, fully pipelined.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | point_x, point_y, point_z (Q16.16)
//  rsp     | out | valid / ready    | pixel_u, pixel_v (Q16.16), status
//  csr     | in  | csr_write_en     | csr_index, csr_data
//
// One point enters per cycle unless a held result stalls the pipeline; the stages are
// an input stage, 56 divider steps and 13 math stages.
// The depth divider retires one quotient bit per stage and lane and divides by the depth.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module pinhole_distortion_projection_unit #(
   parameter logic signed [31:0] RADIAL_K3 = 32'sd0
) (
   input  logic             clock,
   input  logic             reset,
   pdp_point_if.sink        req,
   pdp_pixel_if.source      rsp,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import pdp_pkg::*;

   localparam int POST = 13;

   logic [31:0]        focal_x_ff, focal_y_ff;
   logic signed [31:0] center_x_ff, center_y_ff, k1_ff, k2_ff, p1_ff, p2_ff;

   logic adv;

   div_type                div_ff [0:DIV_STEPS];
   logic [DIV_STEPS:0]     dv_ff;
   logic [POST:1]          pv_ff;
   logic [POST:1]          sat_ff;
   logic [POST:1]          bad_ff;
   logic signed [31:0]     x_ff [1:10];
   logic signed [31:0]     y_ff [1:10];

   logic signed [63:0] pxx_ff, pyy_ff, pxy_ff;
   logic signed [31:0] xx_ff, yy_ff, xy_ff;
   logic signed [31:0] r2_ff [3:5];
   logic signed [63:0] pr4_ff, pk1_ff, pp1xy_ff, pp2xy_ff;
   logic signed [31:0] t2x_ff, t2y_ff;
   logic signed [31:0] r4_ff, p1xy_ff, p2xy_ff;
   logic signed [31:0] k1r2_ff [5:8];
   logic signed [63:0] pt2x_ff, pt2y_ff;
   logic signed [63:0] pr6_ff, pk2_ff;
   logic signed [31:0] tx_ff [6:10];
   logic signed [31:0] ty_ff [6:10];
   logic signed [31:0] r6_ff;
   logic signed [31:0] k2r4_ff [7:8];
   logic signed [63:0] pk3_ff;
   logic signed [31:0] radial_ff;
   logic signed [63:0] pxr_ff, pyr_ff;
   logic signed [31:0] xd_ff, yd_ff;
   logic signed [64:0] pu_ff, pv65_ff;
   logic signed [31:0] u_ff, v_ff;
   logic [1:0]         status_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 32'd32768000;
         focal_y_ff  <= 32'd32768000;
         center_x_ff <= 32'sd20971520;
         center_y_ff <= 32'sd15728640;
         k1_ff       <= '0;
         k2_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_FOCAL_X:   focal_x_ff  <= csr_data;
            REG_FOCAL_Y:   focal_y_ff  <= csr_data;
            REG_CENTER_X:  center_x_ff <= $signed(csr_data);
            REG_CENTER_Y:  center_y_ff <= $signed(csr_data);
            REG_RADIAL_1:  k1_ff       <= $signed(csr_data);
            REG_RADIAL_2:  k2_ff       <= $signed(csr_data);
            REG_TANGENT_1: p1_ff       <= $signed(csr_data);
            REG_TANGENT_2: p2_ff       <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless the result is held
   assign adv       = !pv_ff[POST] || rsp.ready;
   assign req.ready = adv;

   // Load the divider front stage
   div_type div_in;
   logic [31:0] abs_x, abs_y;
   always_comb begin
      abs_x = req.point_x[31] ? 32'(32'd0 - req.point_x) : req.point_x;
      abs_y = req.point_y[31] ? 32'(32'd0 - req.point_y) : req.point_y;
      div_in.bad    = req.point_z[31] || (req.point_z == 32'sd0);
      div_in.neg_x  = req.point_x[31];
      div_in.neg_y  = req.point_y[31];
      div_in.den    = div_in.bad ? 31'd1 : req.point_z[30:0];
      div_in.lx.num = {abs_x, 24'd0};
      div_in.lx.rem = '0;
      div_in.lx.quo = '0;
      div_in.ly.num = {abs_y, 24'd0};
      div_in.ly.rem = '0;
      div_in.ly.quo = '0;
   end

   // Divider stages: one quotient bit per stage and lane
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            div_ff[k].bad   <= div_ff[k-1].bad;
            div_ff[k].neg_x <= div_ff[k-1].neg_x;
            div_ff[k].neg_y <= div_ff[k-1].neg_y;
            div_ff[k].den   <= div_ff[k-1].den;
            div_ff[k].lx    <= div_step(div_ff[k-1].lx, div_ff[k-1].den);
            div_ff[k].ly    <= div_step(div_ff[k-1].ly, div_ff[k-1].den);
         end
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         pv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DIV_STEPS-1:0], req.valid};
         pv_ff <= {pv_ff[POST-1:1], dv_ff[DIV_STEPS]};
      end
   end

   // Combinational clips of each stage
   clip_type cx1, cy1;
   clip_type cxx, cyy, cxy, cr2;
   clip_type ct2x, ct2y;
   clip_type cr4, ck1, cp1xy, cp2xy;
   clip_type cpt2x, cpt2y, ctx, cty;
   clip_type cr6, ck2;
   clip_type ck3, crad;
   clip_type cxr, cyr, cxd, cyd;
   clip_type cu, cv;
   logic signed [64:0] pu_sh, pv_sh;

   always_comb begin
      cx1   = quo_clip(div_ff[DIV_STEPS].lx.quo, div_ff[DIV_STEPS].neg_x);
      cy1   = quo_clip(div_ff[DIV_STEPS].ly.quo, div_ff[DIV_STEPS].neg_y);
      cxx   = qscale(pxx_ff);
      cyy   = qscale(pyy_ff);
      cxy   = qscale(pxy_ff);
      cr2   = clip48(48'(cxx.val) + 48'(cyy.val));
      ct2x  = clip48(48'(r2_ff[3]) + (48'(xx_ff) <<< 1));
      ct2y  = clip48(48'(r2_ff[3]) + (48'(yy_ff) <<< 1));
      cr4   = qscale(pr4_ff);
      ck1   = qscale(pk1_ff);
      cp1xy = qscale(pp1xy_ff);
      cp2xy = qscale(pp2xy_ff);
      cpt2x = qscale(pt2x_ff);
      cpt2y = qscale(pt2y_ff);
      ctx   = clip48((48'(p1xy_ff) <<< 1) + 48'(cpt2x.val));
      cty   = clip48(48'(cpt2y.val) + (48'(p2xy_ff) <<< 1));
      cr6   = qscale(pr6_ff);
      ck2   = qscale(pk2_ff);
      ck3   = qscale(pk3_ff);
      crad  = clip48(Q24_ONE + 48'(k1r2_ff[8]) + 48'(k2r4_ff[8]) + 48'(ck3.val));
      cxr   = qscale(pxr_ff);
      cyr   = qscale(pyr_ff);
      cxd   = clip48(48'(cxr.val) + 48'(tx_ff[10]));
      cyd   = clip48(48'(cyr.val) + 48'(ty_ff[10]));
      pu_sh = pu_ff >>> 24;
      pv_sh = pv65_ff >>> 24;
      cu    = clip48(pu_sh[47:0] + 48'(center_x_ff));
      cv    = clip48(pv_sh[47:0] + 48'(center_y_ff));
   end

   // Math stages after the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         // Stage 1: normalized coordinates
         x_ff[1]   <= cx1.val;
         y_ff[1]   <= cy1.val;
         sat_ff[1] <= cx1.sat | cy1.sat;
         bad_ff[1] <= div_ff[DIV_STEPS].bad;
         for (int k = 2; k <= POST; k++) begin
            bad_ff[k] <= bad_ff[k-1];
         end
         for (int k = 2; k <= 10; k++) begin
            x_ff[k] <= x_ff[k-1];
            y_ff[k] <= y_ff[k-1];
         end

         // Stage 2: squares and cross product
         pxx_ff    <= x_ff[1] * x_ff[1];
         pyy_ff    <= y_ff[1] * y_ff[1];
         pxy_ff    <= x_ff[1] * y_ff[1];
         sat_ff[2] <= sat_ff[1];

         // Stage 3: scale, r squared
         xx_ff     <= cxx.val;
         yy_ff     <= cyy.val;
         xy_ff     <= cxy.val;
         r2_ff[3]  <= cr2.val;
         sat_ff[3] <= sat_ff[2] | cxx.sat | cyy.sat | cxy.sat | cr2.sat;

         // Stage 4: r2 products and tangential bases
         pr4_ff    <= r2_ff[3] * r2_ff[3];
         pk1_ff    <= k1_ff * r2_ff[3];
         pp1xy_ff  <= p1_ff * xy_ff;
         pp2xy_ff  <= p2_ff * xy_ff;
         t2x_ff    <= ct2x.val;
         t2y_ff    <= ct2y.val;
         r2_ff[4]  <= r2_ff[3];
         sat_ff[4] <= sat_ff[3] | ct2x.sat | ct2y.sat;

         // Stage 5: r4 and tangential products
         r4_ff      <= cr4.val;
         k1r2_ff[5] <= ck1.val;
         p1xy_ff    <= cp1xy.val;
         p2xy_ff    <= cp2xy.val;
         pt2x_ff    <= p2_ff * t2x_ff;
         pt2y_ff    <= p1_ff * t2y_ff;
         r2_ff[5]   <= r2_ff[4];
         sat_ff[5]  <= sat_ff[4] | cr4.sat | ck1.sat | cp1xy.sat | cp2xy.sat;

         // Stage 6: r6 product, tangential sums
         pr6_ff     <= r2_ff[5] * r4_ff;
         pk2_ff     <= k2_ff * r4_ff;
         tx_ff[6]   <= ctx.val;
         ty_ff[6]   <= cty.val;
         k1r2_ff[6] <= k1r2_ff[5];
         sat_ff[6]  <= sat_ff[5] | cpt2x.sat | cpt2y.sat | ctx.sat | cty.sat;

         // Stage 7: r6 and k2 term
         r6_ff      <= cr6.val;
         k2r4_ff[7] <= ck2.val;
         k1r2_ff[7] <= k1r2_ff[6];
         sat_ff[7]  <= sat_ff[6] | cr6.sat | ck2.sat;

         // Stage 8: k3 product
         pk3_ff     <= RADIAL_K3 * r6_ff;
         k1r2_ff[8] <= k1r2_ff[7];
         k2r4_ff[8] <= k2r4_ff[7];
         sat_ff[8]  <= sat_ff[7];

         // Stage 9: radial factor
         radial_ff <= crad.val;
         sat_ff[9] <= sat_ff[8] | ck3.sat | crad.sat;

         for (int k = 7; k <= 10; k++) begin
            tx_ff[k] <= tx_ff[k-1];
            ty_ff[k] <= ty_ff[k-1];
         end

         // Stage 10: apply radial
         pxr_ff     <= x_ff[9] * radial_ff;
         pyr_ff     <= y_ff[9] * radial_ff;
         sat_ff[10] <= sat_ff[9];

         // Stage 11: distorted coordinates
         xd_ff      <= cxd.val;
         yd_ff      <= cyd.val;
         sat_ff[11] <= sat_ff[10] | cxr.sat | cyr.sat | cxd.sat | cyd.sat;

         // Stage 12: focal products
         pu_ff      <= $signed({1'b0, focal_x_ff}) * xd_ff;
         pv65_ff    <= $signed({1'b0, focal_y_ff}) * yd_ff;
         sat_ff[12] <= sat_ff[11];

         // Stage 13: principal point, status
         sat_ff[13] <= sat_ff[12] | cu.sat | cv.sat;
         if (bad_ff[12]) begin
            u_ff      <= '0;
            v_ff      <= '0;
            status_ff <= ST_DEPTH;
         end else begin
            u_ff      <= cu.val;
            v_ff      <= cv.val;
            status_ff <= (sat_ff[12] | cu.sat | cv.sat) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp.valid   = pv_ff[POST];
   assign rsp.pixel_u = u_ff;
   assign rsp.pixel_v = v_ff;
   assign rsp.status  = status_ff;

   // Hold every valid bit while the result waits
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_ff) && $stable(pv_ff))
      else $error("pipeline moved during stall");

   // A bad depth yields a zero pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_DEPTH |-> rsp.pixel_u == 32'sd0 && rsp.pixel_v == 32'sd0)
      else $error("bad depth with nonzero pixel");

   // Status and depth flag agree at the output
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (bad_ff[POST] == (rsp.status == ST_DEPTH)))
      else $error("status does not match depth flag");

endmodule

@@ dv/pdp_projection_tb_if.sv @@
// Expected-result record type used by the testbench scoreboard.
`timescale 1ns / 1ps
package pdp_tb_types;
   typedef struct {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic [1:0]         status;
   } pixel_item_type;
endpackage

@@ dv/pinhole_distortion_projection_unit_tb.sv @@
// Self-checking testbench: random and directed points projected through the unit and scored.
`timescale 1ns / 1ps
module pinhole_distortion_projection_unit_tb;
   import pdp_pkg::*;
   import pdp_tb_types::*;

   localparam int LATENCY = 70;
   localparam logic signed [31:0] DUT_K3 = 32'sd0;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   bit          failed;

   pdp_point_if req ();
   pdp_pixel_if rsp ();

   pinhole_distortion_projection_unit #(.RADIAL_K3(DUT_K3)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Scoreboard: projects each accepted point and checks pixels in order
   class pixel_scoreboard_type;
      logic [31:0]    fx, fy, cx, cy, k1, k2, p1, p2;
      pixel_item_type pending[$];
      int             errors;

      function void load_defaults();
         fx = 32'd32768000; fy = 32'd32768000;
         cx = 32'd20971520; cy = 32'd15728640;
         k1 = '0; k2 = '0; p1 = '0; p2 = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_FOCAL_X:   fx = val;
            REG_FOCAL_Y:   fy = val;
            REG_CENTER_X:  cx = val;
            REG_CENTER_Y:  cy = val;
            REG_RADIAL_1:  k1 = val;
            REG_RADIAL_2:  k2 = val;
            REG_TANGENT_1: p1 = val;
            REG_TANGENT_2: p2 = val;
            default: ;
         endcase
      endfunction

      function longint limit(longint v, ref bit sat);
         if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // Q8.24 product with floor rounding
      function longint fmul(longint a, longint b, ref bit sat);
         return limit((a * b) >>> 24, sat);
      endfunction

      function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
         pixel_item_type e;
         bit             sat;
         longint         x, y, xx, yy, xy, r2, r4, r6, rad, tx, ty, xd, yd, q1, q2;
         longint         kk1, kk2, kk3, pp1, pp2;
         sat = 0;
         if (pz <= 0) begin
            e.pixel_u = '0; e.pixel_v = '0; e.status = ST_DEPTH;
            pending.push_back(e);
            return;
         end
         kk1 = $signed(k1); kk2 = $signed(k2); pp1 = $signed(p1); pp2 = $signed(p2);
         kk3 = longint'(DUT_K3);
         x = limit((longint'(px) <<< 24) / longint'(pz), sat);
         y = limit((longint'(py) <<< 24) / longint'(pz), sat);
         xx = fmul(x, x, sat);
         yy = fmul(y, y, sat);
         xy = fmul(x, y, sat);
         r2 = limit(xx + yy, sat);
         r4 = fmul(r2, r2, sat);
         r6 = fmul(r2, r4, sat);
         rad = limit(64'sd16777216 + fmul(kk1, r2, sat) + fmul(kk2, r4, sat)
                     + fmul(kk3, r6, sat), sat);
         q1 = limit(r2 + 2 * xx, sat);
         tx = limit(2 * fmul(pp1, xy, sat) + fmul(pp2, q1, sat), sat);
         q2 = limit(r2 + 2 * yy, sat);
         ty = limit(fmul(pp1, q2, sat) + 2 * fmul(pp2, xy, sat), sat);
         xd = limit(fmul(x, rad, sat) + tx, sat);
         yd = limit(fmul(y, rad, sat) + ty, sat);
         e.pixel_u = 32'(limit(((longint'({32'd0, fx}) * xd) >>> 24)
                               + longint'($signed(cx)), sat));
         e.pixel_v = 32'(limit(((longint'({32'd0, fy}) * yd) >>> 24)
                               + longint'($signed(cy)), sat));
         e.status = sat ? ST_SAT : ST_OK;
         pending.push_back(e);
      endfunction

      function void check_pixel(logic signed [31:0] u, logic signed [31:0] v,
                                logic [1:0] st);
         pixel_item_type e;
         if (pending.size() == 0) begin
            $error("unexpected pixel u=%0d v=%0d status=%0d", u, v, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (u !== e.pixel_u) begin
            $error("pixel_u expected %0d actual %0d", e.pixel_u, u);
            errors++;
         end
         if (v !== e.pixel_v) begin
            $error("pixel_v expected %0d actual %0d", e.pixel_v, v);
            errors++;
         end
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st);
            errors++;
         end
      endfunction
   endclass

   pixel_scoreboard_type board;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #20ms;
      $display("pinhole_distortion_projection_unit_tb: FAIL");
      $finish;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         board.note_point(req.point_x, req.point_y, req.point_z);
      if (!reset && rsp.valid && rsp.ready)
         board.check_pixel(rsp.pixel_u, rsp.pixel_v, rsp.status);
   end

   // Receiver: random stalls, or a long counted hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      board.set_reg(idx, val);
   endtask

   // Offer one point and hold it until accepted; valid stays up for the next one
   task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.point_x <= px;
      req.point_y <= py;
      req.point_z <= pz;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0: return 32'h8000_0000 | $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom;
         default: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
      endcase
   endfunction

   // A point in front of the camera with a modest field of view, or now and then random fields
   task automatic send_random_point();
      logic signed [31:0] z;
      if ($urandom_range(9) == 0) begin
         send_point(rand_field(), rand_field(), rand_field());
      end else begin
         z = 32'($urandom_range(32'h00FF_FFFF, 32'h0000_4000));
         send_point(32'($signed($urandom_range(2 * z)) - z),
                    32'($signed($urandom_range(2 * z)) - z), z);
      end
   endtask

   task automatic random_config(bit wild);
      write_reg(REG_FOCAL_X, wild ? $urandom : $urandom_range(32'h0400_0000, 32'h0010_0000));
      write_reg(REG_FOCAL_Y, wild ? $urandom : $urandom_range(32'h0400_0000, 32'h0010_0000));
      write_reg(REG_CENTER_X, wild ? $urandom : $urandom_range(32'h0400_0000));
      write_reg(REG_CENTER_Y, wild ? $urandom : $urandom_range(32'h0400_0000));
      write_reg(REG_RADIAL_1, wild ? $urandom : 32'($signed($urandom_range(8000000)) - 4000000));
      write_reg(REG_RADIAL_2, wild ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000));
      write_reg(REG_TANGENT_1, wild ? $urandom : 32'($signed($urandom_range(200000)) - 100000));
      write_reg(REG_TANGENT_2, wild ? $urandom : 32'($signed($urandom_range(200000)) - 100000));
   endtask

   initial begin
      board = new();
      board.load_defaults();
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = REG_FOCAL_X;
      csr_data = '0;
      req.valid = 1'b0;
      req.point_x = '0;
      req.point_y = '0;
      req.point_z = '0;
      rsp.ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: depth cases, field extremes, defaults
      send_point(32'sd0, 32'sd0, 32'sd65536);
      send_point(32'sd65536, -32'sd65536, 32'sd0);
      send_point(32'sd1, 32'sd1, -32'sd1);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sd32768, -32'sd32768, 32'sd65536);
      send_point(-32'sd1, -32'sd1, 32'sd1);
      send_point(32'sd200000, 32'sd150000, 32'sd65536);
      drain();

      // Distortion on, then extreme register values
      write_reg(REG_RADIAL_1, 32'sh0080_0000);
      write_reg(REG_RADIAL_2, -32'sh0040_0000);
      write_reg(REG_TANGENT_1, 32'sh0001_0000);
      write_reg(REG_TANGENT_2, -32'sh0001_0000);
      send_point(32'sd40000, -32'sd30000, 32'sd65536);
      send_point(-32'sd65536, 32'sd65536, 32'sd65536);
      send_point(32'sd300000, 32'sd300000, 32'sd65536);
      drain();
      write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
      write_reg(REG_FOCAL_Y, 32'h0000_0000);
      write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
      write_reg(REG_CENTER_Y, 32'h8000_0000);
      write_reg(REG_RADIAL_1, 32'h7FFF_FFFF);
      write_reg(REG_RADIAL_2, 32'h8000_0000);
      write_reg(REG_TANGENT_1, 32'h8000_0000);
      write_reg(REG_TANGENT_2, 32'h7FFF_FFFF);
      send_point(32'sd65536, 32'sd65536, 32'sd65536);
      send_point(-32'sd100, 32'sd100, 32'sd65536);
      send_point(32'sd0, 32'sd0, 32'sd65536);
      drain();

      // Random phases across idling patterns and settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
            default: begin send_idle_pct = 38; recv_idle_pct = 38; end
         endcase
         random_config(phase == 5);
         if (phase == 2) hold_cycles = 300;
         for (int n = 0; n < 80; n++) begin
            send_random_point();
            if (n == 40) begin
               // pause until every pixel is back
               req.valid <= 1'b0;
               while (board.pending.size() != 0) @(negedge clock);
            end
         end
         drain();
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("pinhole_distortion_projection_unit_tb: PASS");
      else
         $display("pinhole_distortion_projection_unit_tb: FAIL");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/pdp_pkg.sv
hdl/pdp_if.sv
hdl/pinhole_distortion_projection_unit.sv
dv/pdp_projection_tb_if.sv
dv/pinhole_distortion_projection_unit_tb.sv
